### rtl/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg: shared types and constants of the bad-sector range remapper
// Opcodes, status codes, table and segment defaults, and the command and
// status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bsr_pkg;

  localparam int TableDepthDefault  = 64;
  localparam int MaxSegmentsDefault = 16;
  localparam logic [15:0] SectorSizeReset = 16'd512;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_APPEND   = 2'd1,
    OP_REMAP    = 2'd2,
    OP_RESERVED = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  // Sector value written with a segment.
  typedef enum logic [1:0] {
    SEC_CUR   = 2'd0,  // current start sector
    SEC_REMAP = 2'd1,  // alternate + (current - bad first)
    SEC_ALT   = 2'd2   // alternate first
  } sec_sel_t;

  // Count value written with a segment.
  typedef enum logic [2:0] {
    CNT_BL_S  = 3'd0,  // bad last - current + 1
    CNT_BF_S  = 3'd1,  // bad first - current
    CNT_LS_BF = 3'd2,  // request last - bad first + 1
    CNT_BL_BF = 3'd3,  // bad last - bad first + 1
    CNT_LS_S  = 3'd4   // request last - current + 1
  } cnt_sel_t;

  typedef struct packed {
    logic     req_ready;
    logic     clr_table;
    logic     append;
    logic     load_req;
    logic     tbl_rd;
    logic     idx_inc;
    logic     piece;
    sec_sel_t sec_sel;
    cnt_sel_t cnt_sel;
    logic     advance;
    logic     mul;
    logic     acc;
    logic     seg_rd;
    logic     out_seg;
    logic     out_single;
    status_t  single_status;
  } bsr_cmd_t;

  typedef struct packed {
    logic    req_valid;
    logic [1:0] opcode;
    logic    table_full;
    logic    idx_end;
    logic    ls_lt_bf;
    logic    s_gt_bl;
    logic    s_ge_bf;
    logic    ls_le_bl;
    logic    ls_ge_bf;
    logic    ovf1;
    logic    ovf2;
    logic    out_free;
    logic    seg_last;
  } bsr_stat_t;

endpackage

`default_nettype wire

### rtl/bsr_if.sv
// ----------------------------------------------------------------------------
// bsr_if: channel interfaces of the bad-sector range remapper
// Request, result and sector-size configuration channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [30:0] request_sector;
  logic [15:0] request_count;
  logic [31:0] request_addr;
  logic [30:0] entry_bad_first;
  logic [30:0] entry_bad_last;
  logic [30:0] entry_alt_first;

  modport source (output valid, opcode, request_sector, request_count, request_addr,
                  entry_bad_first, entry_bad_last, entry_alt_first, input ready);
  modport sink (input valid, opcode, request_sector, request_count, request_addr,
                entry_bad_first, entry_bad_last, entry_alt_first, output ready);
endinterface

interface bsr_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] seg_sector;
  logic [15:0] seg_count;
  logic [31:0] seg_addr;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, seg_sector, seg_count, seg_addr, status, last,
                  input ready);
  modport sink (input valid, seg_sector, seg_count, seg_addr, status, last,
                output ready);
endinterface

interface bsr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] sector_size;

  modport source (output valid, sector_size, input ready);
  modport sink (input valid, sector_size, output ready);
endinterface

`default_nettype wire

### rtl/bsr_ram.sv
// ----------------------------------------------------------------------------
// bsr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr,
  output logic      [WIDTH-1:0]      q
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q <= mem[raddr];
    end
  end
endmodule

`default_nettype wire

### rtl/bsr_datapath.sv
// ----------------------------------------------------------------------------
// bsr_datapath: table, segment store and arithmetic of the remapper
// Holds the cluster table, the walk registers, the segment list and the
// output register, and carries out the controller's commands.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_datapath
  import bsr_pkg::*;
#(
  parameter int TABLE_DEPTH  = TableDepthDefault,
  parameter int MAX_SEGMENTS = MaxSegmentsDefault
) (
  input  wire logic      clk,
  input  wire logic      rst,
  bsr_in_if.sink         req,
  bsr_out_if.source      seg,
  bsr_cfg_if.sink        cfg,
  input  bsr_cmd_t       cmd,
  output bsr_stat_t      stat
);
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int SEG_AW = $clog2(MAX_SEGMENTS);
  localparam int SEG_CW = $clog2(MAX_SEGMENTS + 1);
  localparam int TBL_W  = 93;
  localparam int SEG_W  = 79;

  logic [15:0]        sector_size;
  logic [CNT_W-1:0]   cluster_count;
  logic [CNT_W-1:0]   idx;
  logic [SEG_CW-1:0]  seg_used;
  logic [SEG_CW-1:0]  rd_pos;
  logic [31:0]        cur_sec;
  logic [31:0]        cur_mem;
  logic signed [33:0] last_sec;
  logic [31:0]        mul_op;
  logic [31:0]        product;

  logic [TBL_W-1:0]   tbl_q;
  logic [SEG_W-1:0]   seg_q;
  logic [30:0]        bf, bl, ga;
  logic signed [33:0] s_ext, bf_ext, bl_ext;
  logic [30:0]        piece_sec;
  logic [31:0]        piece_cnt;

  logic        out_valid;
  logic [30:0] out_sector;
  logic [15:0] out_count;
  logic [31:0] out_addr;
  status_t     out_status;
  logic        out_last;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_size <= SectorSizeReset;
    end else if (cfg.valid) begin
      sector_size <= cfg.sector_size;
    end
  end

  bsr_ram #(.WIDTH(TBL_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (cluster_count[IDX_W-1:0]),
    .wdata ({req.entry_bad_first, req.entry_bad_last, req.entry_alt_first}),
    .re    (cmd.tbl_rd),
    .raddr (idx[IDX_W-1:0]),
    .q     (tbl_q)
  );

  assign bf = tbl_q[92:62];
  assign bl = tbl_q[61:31];
  assign ga = tbl_q[30:0];

  assign s_ext  = $signed({2'b00, cur_sec});
  assign bf_ext = $signed({3'b000, bf});
  assign bl_ext = $signed({3'b000, bl});

  always_comb begin
    case (cmd.sec_sel)
      SEC_CUR:   piece_sec = cur_sec[30:0];
      SEC_REMAP: piece_sec = ga + cur_sec[30:0] - bf;
      SEC_ALT:   piece_sec = ga;
      default:   piece_sec = cur_sec[30:0];
    endcase
    case (cmd.cnt_sel)
      CNT_BL_S:  piece_cnt = {1'b0, bl} - cur_sec + 32'd1;
      CNT_BF_S:  piece_cnt = {1'b0, bf} - cur_sec;
      CNT_LS_BF: piece_cnt = last_sec[31:0] - {1'b0, bf} + 32'd1;
      CNT_BL_BF: piece_cnt = {1'b0, bl} - {1'b0, bf} + 32'd1;
      CNT_LS_S:  piece_cnt = last_sec[31:0] - cur_sec + 32'd1;
      default:   piece_cnt = 32'd0;
    endcase
  end

  bsr_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_segs (
    .clk   (clk),
    .we    (cmd.piece),
    .waddr (seg_used[SEG_AW-1:0]),
    .wdata ({piece_sec, piece_cnt[15:0], cur_mem}),
    .re    (cmd.seg_rd),
    .raddr (rd_pos[SEG_AW-1:0]),
    .q     (seg_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count <= '0;
    end else if (cmd.clr_table) begin
      cluster_count <= '0;
    end else if (cmd.append) begin
      cluster_count <= cluster_count + CNT_W'(1);
    end
  end

  // Walk registers.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      cur_sec  <= {1'b0, req.request_sector};
      cur_mem  <= req.request_addr;
      last_sec <= $signed({3'b000, req.request_sector}) +
                  $signed({18'd0, req.request_count}) - 34'sd1;
      idx      <= '0;
      seg_used <= '0;
      rd_pos   <= '0;
    end else begin
      if (cmd.idx_inc) begin
        idx <= idx + CNT_W'(1);
      end
      if (cmd.piece) begin
        seg_used <= seg_used + SEG_CW'(1);
        mul_op   <= piece_cnt;
        if (cmd.advance) begin
          cur_sec <= {1'b0, bl} + 32'd1;
        end
      end
      if (cmd.mul) begin
        product <= 32'(mul_op * sector_size);
      end
      if (cmd.acc) begin
        cur_mem <= cur_mem + product;
      end
      if (cmd.out_seg) begin
        rd_pos <= rd_pos + SEG_CW'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_seg || cmd.out_single) begin
      out_valid <= 1'b1;
    end else if (seg.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_single) begin
      out_sector <= '0;
      out_count  <= '0;
      out_addr   <= '0;
      out_status <= cmd.single_status;
      out_last   <= 1'b1;
    end else if (cmd.out_seg) begin
      out_sector <= seg_q[78:48];
      out_count  <= seg_q[47:32];
      out_addr   <= seg_q[31:0];
      out_status <= ST_OK;
      out_last   <= stat.seg_last;
    end
  end

  assign seg.valid      = out_valid;
  assign seg.seg_sector = out_sector;
  assign seg.seg_count  = out_count;
  assign seg.seg_addr   = out_addr;
  assign seg.status     = out_status;
  assign seg.last       = out_last;
  assign req.ready      = cmd.req_ready;

  always_comb begin
    stat.req_valid  = req.valid;
    stat.opcode     = req.opcode;
    stat.table_full = (cluster_count == CNT_W'(TABLE_DEPTH));
    stat.idx_end    = (idx >= cluster_count);
    stat.ls_lt_bf   = (last_sec < bf_ext);
    stat.s_gt_bl    = (s_ext > bl_ext);
    stat.s_ge_bf    = (s_ext >= bf_ext);
    stat.ls_le_bl   = (last_sec <= bl_ext);
    stat.ls_ge_bf   = (last_sec >= bf_ext);
    stat.ovf1       = (seg_used >= SEG_CW'(MAX_SEGMENTS - 1));
    stat.ovf2       = (seg_used >= SEG_CW'(MAX_SEGMENTS - 2));
    stat.out_free   = !out_valid || seg.ready;
    stat.seg_last   = ((rd_pos + SEG_CW'(1)) == seg_used);
  end
endmodule

`default_nettype wire

### rtl/bsr_ctrl.sv
// ----------------------------------------------------------------------------
// bsr_ctrl: sequencer of the remapper
// Decodes requests, walks the cluster table case by case, and drives the
// segment write, address step and result readout.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_ctrl
  import bsr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  bsr_stat_t stat,
  output bsr_cmd_t  cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_SINGLE, S_WRD, S_WEV, S_B2, S_C2, S_MUL, S_ACC, S_ORD, S_OLD
  } state_t;

  state_t  state, state_next;
  state_t  ret, ret_next;
  status_t single, single_next;

  always_comb begin
    cmd         = '0;
    state_next  = state;
    ret_next    = ret;
    single_next = single;
    cmd.single_status = single;
    case (state)
      S_IDLE: begin
        cmd.req_ready = 1'b1;
        if (stat.req_valid) begin
          single_next = ST_OK;
          state_next  = S_SINGLE;
          case (stat.opcode)
            OP_CLEAR:  cmd.clr_table = 1'b1;
            OP_APPEND: begin
              if (stat.table_full) begin
                single_next = ST_FULL;
              end else begin
                cmd.append = 1'b1;
              end
            end
            OP_REMAP: begin
              cmd.load_req = 1'b1;
              state_next   = S_WRD;
            end
            default: ;
          endcase
        end
      end
      S_SINGLE: begin
        if (stat.out_free) begin
          cmd.out_single = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_WRD: begin
        if (stat.idx_end) begin
          cmd.piece   = 1'b1;
          cmd.sec_sel = SEC_CUR;
          cmd.cnt_sel = CNT_LS_S;
          state_next  = S_ORD;
        end else begin
          cmd.tbl_rd = 1'b1;
          state_next = S_WEV;
        end
      end
      S_WEV: begin
        if (stat.ls_lt_bf) begin
          cmd.piece   = 1'b1;
          cmd.sec_sel = SEC_CUR;
          cmd.cnt_sel = CNT_LS_S;
          state_next  = S_ORD;
        end else if (stat.s_gt_bl) begin
          cmd.idx_inc = 1'b1;
          state_next  = S_WRD;
        end else if (stat.s_ge_bf && stat.ls_le_bl) begin
          cmd.piece   = 1'b1;
          cmd.sec_sel = SEC_REMAP;
          cmd.cnt_sel = CNT_LS_S;
          state_next  = S_ORD;
        end else if (stat.s_ge_bf) begin
          // Starts inside the cluster and runs past its end.
          if (stat.ovf1) begin
            single_next = ST_OVF;
            state_next  = S_SINGLE;
          end else begin
            cmd.piece   = 1'b1;
            cmd.sec_sel = SEC_REMAP;
            cmd.cnt_sel = CNT_BL_S;
            cmd.advance = 1'b1;
            ret_next    = S_WEV;
            state_next  = S_MUL;
          end
        end else if (stat.ls_ge_bf && stat.ls_le_bl) begin
          // Starts before the cluster and ends inside it.
          if (stat.ovf1) begin
            single_next = ST_OVF;
            state_next  = S_SINGLE;
          end else begin
            cmd.piece   = 1'b1;
            cmd.sec_sel = SEC_CUR;
            cmd.cnt_sel = CNT_BF_S;
            ret_next    = S_B2;
            state_next  = S_MUL;
          end
        end else begin
          // Covers the whole cluster.
          if (stat.ovf2) begin
            single_next = ST_OVF;
            state_next  = S_SINGLE;
          end else begin
            cmd.piece   = 1'b1;
            cmd.sec_sel = SEC_CUR;
            cmd.cnt_sel = CNT_BF_S;
            ret_next    = S_C2;
            state_next  = S_MUL;
          end
        end
      end
      S_B2: begin
        cmd.piece   = 1'b1;
        cmd.sec_sel = SEC_ALT;
        cmd.cnt_sel = CNT_LS_BF;
        state_next  = S_ORD;
      end
      S_C2: begin
        cmd.piece   = 1'b1;
        cmd.sec_sel = SEC_ALT;
        cmd.cnt_sel = CNT_BL_BF;
        cmd.advance = 1'b1;
        ret_next    = S_WEV;
        state_next  = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = ret;
      end
      S_ORD: begin
        cmd.seg_rd = 1'b1;
        state_next = S_OLD;
      end
      S_OLD: begin
        if (stat.out_free) begin
          cmd.out_seg = 1'b1;
          state_next  = stat.seg_last ? S_IDLE : S_ORD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ret    <= S_IDLE;
      single <= ST_OK;
    end else begin
      state  <= state_next;
      ret    <= ret_next;
      single <= single_next;
    end
  end
endmodule

`default_nettype wire

### rtl/bad_sector_range_remapper.sv
// ----------------------------------------------------------------------------
// bad_sector_range_remapper: splits read requests around bad-sector clusters
// Top level: joins the sequencer and the datapath.
// ----------------------------------------------------------------------------
// The req channel carries one request per handshake: opcode 0 clears the
// cluster table, opcode 1 appends a cluster (first bad, last bad, first
// alternate sector), opcode 2 remaps a read given as sector, count and
// memory address. The seg channel returns the results: one item for clear,
// append or an unused opcode, and for a remap one item per segment, the last
// flagged by last. A remap that would need more than MAX_SEGMENTS segments
// returns one item with status 2; an append to a full table returns status 1.
// The cfg channel writes sector_size, the bytes per sector; it is always
// ready. The user must write it only while the block is idle; the block
// itself does not enforce this. The block works on one request at a time.
// A remap reads and evaluates each table entry it visits; each split writes
// a segment, multiplies and adds the address; then each segment is read out
// through the segment RAM's registered port. A new request is taken while
// the final result still waits in the output register. A stalled receiver
// only holds the output register and the sequencer; nothing is dropped.
// Reset clears the table count, the output valid and the sequencer, and
// sets sector_size to 512. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bad_sector_range_remapper
  import bsr_pkg::*;
#(
  parameter int TABLE_DEPTH  = TableDepthDefault,
  parameter int MAX_SEGMENTS = MaxSegmentsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  bsr_in_if.sink    req,
  bsr_out_if.source seg,
  bsr_cfg_if.sink   cfg
);
  bsr_cmd_t  cmd;
  bsr_stat_t stat;

  // The sequencer decides each step of the table walk from the compare flags.
  bsr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // The datapath owns all storage and arithmetic.
  bsr_datapath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .seg  (seg),
    .cfg  (cfg),
    .cmd  (cmd),
    .stat (stat)
  );
endmodule

`default_nettype wire

### rtl/bsr_checker.sv
// ----------------------------------------------------------------------------
// bsr_port_checker: port-level checks of the remapper
// Watches the request and result channels over time.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_port_checker
  import bsr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        seg_valid,
  input wire logic        seg_ready,
  input wire logic [1:0]  seg_status,
  input wire logic        seg_last,
  input wire logic [31:0] seg_addr
);
  // Error results always stand alone.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg_status != ST_OK |-> seg_last)
    else $error("error status without last");

  // One request at a time: the block is busy right after an accept.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg_ready |=> seg_valid && $stable(seg_addr))
    else $error("stalled result changed");

  // Nothing is shown right after reset.
  a_rst: assert property (@(posedge clk) rst |=> !seg_valid)
    else $error("result valid after reset");
endmodule

bind bad_sector_range_remapper bsr_port_checker u_bsr_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .seg_valid  (seg.valid),
  .seg_ready  (seg.ready),
  .seg_status (seg.status),
  .seg_last   (seg.last),
  .seg_addr   (seg.seg_addr)
);

`default_nettype wire

### tb/bsr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bsr_checker: remap predictor and result scoreboard
// Watches the request, result and sector-size channels. It keeps its own copy
// of the cluster table, works out the segments for every accepted request and
// compares each accepted result, field by field, with the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_checker
  import bsr_pkg::*;
#(
  parameter int TABLE_DEPTH  = TableDepthDefault,
  parameter int MAX_SEGMENTS = MaxSegmentsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  bsr_in_if.sink    req,
  bsr_out_if.sink   seg,
  bsr_cfg_if.sink   cfg,
  output int        fail_count,
  output int        pending_count
);

  typedef struct packed {
    logic [30:0] sector;
    logic [15:0] count;
    logic [31:0] addr;
    logic [1:0]  status;
    logic        last;
  } seg_item_t;

  seg_item_t expected_segs[$];

  logic [15:0]  sector_size;
  logic [30:0]  tbl_first[TABLE_DEPTH];
  logic [30:0]  tbl_last[TABLE_DEPTH];
  logic [30:0]  tbl_alt[TABLE_DEPTH];
  int           tbl_used;

  // The address step uses the whole signed count, wrapped to 32 bits.
  function automatic logic [31:0] next_addr(logic [31:0] a, longint c);
    longint unsigned prod;
    prod = longint'(c) * longint'(sector_size);
    return a + prod[31:0];
  endfunction

  function automatic seg_item_t single(status_t st);
    seg_item_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // Splits one read request around the clusters and queues its segments.
  task automatic predict_remap(logic [30:0] sec, logic [15:0] cnt, logic [31:0] addr);
    longint    s_sec[MAX_SEGMENTS];
    longint    s_cnt[MAX_SEGMENTS];
    logic [31:0] s_mem[MAX_SEGMENTS];
    int        e, i, used;
    longint    lastsec, bf, bl, ga, s;
    bit        ovf;
    seg_item_t r;
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      s_sec[k] = 0; s_cnt[k] = 0; s_mem[k] = '0;
    end
    s_sec[0] = sec; s_cnt[0] = cnt; s_mem[0] = addr;
    used = 1; e = 0; i = 0; ovf = 1'b0;
    lastsec = s_sec[0] + s_cnt[0] - 1;
    while (i < tbl_used) begin
      bf = tbl_first[i]; bl = tbl_last[i]; ga = tbl_alt[i]; s = s_sec[e];
      if (lastsec < bf) break;
      if (s > bl) begin
        i++;
        continue;
      end
      if (s >= bf && lastsec <= bl) begin
        s_sec[e] = ga + s - bf;
        break;
      end
      if (s >= bf) begin
        if (e + 1 >= MAX_SEGMENTS) begin ovf = 1'b1; break; end
        s_cnt[e+1] = s_cnt[e] - (bl - s + 1);
        s_cnt[e] -= s_cnt[e+1];
        s_sec[e+1] = bl + 1;
        s_mem[e+1] = next_addr(s_mem[e], s_cnt[e]);
        s_sec[e] = ga + s - bf;
        e++; used++;
        continue;
      end
      if (lastsec >= bf && lastsec <= bl) begin
        if (e + 1 >= MAX_SEGMENTS) begin ovf = 1'b1; break; end
        s_cnt[e+1] = lastsec - bf + 1;
        s_cnt[e] -= s_cnt[e+1];
        s_sec[e+1] = ga;
        s_mem[e+1] = next_addr(s_mem[e], s_cnt[e]);
        used++;
        break;
      end
      if (e + 2 >= MAX_SEGMENTS) begin ovf = 1'b1; break; end
      s_sec[e+1] = ga;
      s_cnt[e+1] = bl - bf + 1;
      s_cnt[e] = bf - s;
      s_mem[e+1] = next_addr(s_mem[e], s_cnt[e]);
      s_cnt[e+2] = lastsec - bl;
      s_sec[e+2] = bl + 1;
      s_mem[e+2] = next_addr(s_mem[e+1], s_cnt[e+1]);
      e += 2; used += 2;
    end
    if (ovf) begin
      expected_segs.push_back(single(ST_OVF));
    end else begin
      for (int k = 0; k < used; k++) begin
        r.sector = s_sec[k][30:0];
        r.count  = s_cnt[k][15:0];
        r.addr   = s_mem[k];
        r.status = ST_OK;
        r.last   = (k + 1 == used);
        expected_segs.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin
    seg_item_t want;
    if (rst) begin
      sector_size <= SectorSizeReset;
      tbl_used = 0;
      fail_count = 0;
      pending_count <= 0;
    end else begin
      if (cfg.valid && cfg.ready) sector_size <= cfg.sector_size;
      if (req.valid && req.ready) begin
        case (req.opcode)
          OP_CLEAR: begin
            tbl_used = 0;
            expected_segs.push_back(single(ST_OK));
          end
          OP_APPEND: begin
            if (tbl_used >= TABLE_DEPTH) begin
              expected_segs.push_back(single(ST_FULL));
            end else begin
              tbl_first[tbl_used] = req.entry_bad_first;
              tbl_last[tbl_used]  = req.entry_bad_last;
              tbl_alt[tbl_used]   = req.entry_alt_first;
              tbl_used++;
              expected_segs.push_back(single(ST_OK));
            end
          end
          OP_REMAP: predict_remap(req.request_sector, req.request_count, req.request_addr);
          default: expected_segs.push_back(single(ST_OK));
        endcase
      end
      if (seg.valid && seg.ready) begin
        if (expected_segs.size() == 0) begin
          $error("unexpected result: sector %0d count %0d", seg.seg_sector, seg.seg_count);
          fail_count++;
        end else begin
          want = expected_segs.pop_front();
          if (seg.seg_sector !== want.sector) begin
            $error("seg_sector: expected %0h actual %0h", want.sector, seg.seg_sector);
            fail_count++;
          end
          if (seg.seg_count !== want.count) begin
            $error("seg_count: expected %0h actual %0h", want.count, seg.seg_count);
            fail_count++;
          end
          if (seg.seg_addr !== want.addr) begin
            $error("seg_addr: expected %0h actual %0h", want.addr, seg.seg_addr);
            fail_count++;
          end
          if (seg.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, seg.status);
            fail_count++;
          end
          if (seg.last !== want.last) begin
            $error("last: expected %0d actual %0d", want.last, seg.last);
            fail_count++;
          end
        end
      end
      pending_count <= expected_segs.size();
    end
  end

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the bad-sector range remapper
// Loads cluster tables, sends directed and random remap requests with random
// gaps and result stalls, and changes the sector size between phases. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import bsr_pkg::*;

  localparam int WatchdogLimit = 20000;
  // The settle time before a sector-size write and at the end of the run.
  localparam int SettleCycles  = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending_count;
  int   idle_cycles;
  int   rx_wait;
  bit   long_stall;

  always #4 clk = ~clk;

  bsr_in_if  req_if ();
  bsr_out_if seg_if ();
  bsr_cfg_if cfg_if ();

  bad_sector_range_remapper u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .seg (seg_if.source),
    .cfg (cfg_if.sink)
  );

  bsr_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req_if.sink),
    .seg           (seg_if.sink),
    .cfg           (cfg_if.sink),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Offer one request and hold it until the block takes it. Valid is lowered
  // only when a gap follows, so it never drops and rises in the same step.
  task automatic send_request(opcode_t op, logic [30:0] sec, logic [15:0] cnt,
                              logic [31:0] addr, logic [30:0] bad_first,
                              logic [30:0] bad_last, logic [30:0] alt_first);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid           <= 1'b1;
    req_if.opcode          <= op;
    req_if.request_sector  <= sec;
    req_if.request_count   <= cnt;
    req_if.request_addr    <= addr;
    req_if.entry_bad_first <= bad_first;
    req_if.entry_bad_last  <= bad_last;
    req_if.entry_alt_first <= alt_first;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic send_raw(logic [1:0] op);
    send_request(opcode_t'(op), 31'($urandom()), 16'($urandom()), $urandom(),
                 31'($urandom()), 31'($urandom()), 31'($urandom()));
  endtask

  task automatic remap(logic [30:0] sec, logic [15:0] cnt, logic [31:0] addr);
    send_request(OP_REMAP, sec, cnt, addr, '0, '0, '0);
  endtask

  task automatic add_cluster(logic [30:0] f, logic [30:0] l, logic [30:0] a);
    send_request(OP_APPEND, '0, '0, '0, f, l, a);
  endtask

  // Drain all results, let the block settle, then write the sector size.
  task automatic set_sector_size(logic [15:0] size);
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_if.valid       <= 1'b1;
    cfg_if.sector_size <= size;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // Builds an ordered table of n small clusters starting near base.
  task automatic load_table(int n, logic [30:0] base);
    logic [30:0] pos;
    logic [30:0] len;
    pos = base;
    send_request(OP_CLEAR, '0, '0, '0, '0, '0, '0);
    for (int k = 0; k < n; k++) begin
      pos = pos + 31'($urandom_range(0, 8));
      len = 31'($urandom_range(0, 5));
      add_cluster(pos, pos + len, 31'($urandom_range(0, 32'h7fff_ffff)));
      pos = pos + len + 31'd1;
    end
  endtask

  // Receiver: holds ready low for a random draw after each accepted result, plus one long hold-off.
  always @(posedge clk) begin
    int wait_draw;
    if (rst) begin
      seg_if.ready <= 1'b0;
      rx_wait      <= 0;
    end else if (long_stall) begin
      seg_if.ready <= 1'b0;
    end else if (seg_if.valid && seg_if.ready) begin
      wait_draw = $urandom_range(0, 6);
      rx_wait      <= wait_draw;
      seg_if.ready <= (wait_draw == 0);
    end else if (rx_wait > 0) begin
      rx_wait      <= rx_wait - 1;
      seg_if.ready <= (rx_wait == 1);
    end else begin
      seg_if.ready <= 1'b1;
    end
  end

  initial begin
    long_stall = 1'b0;
    wait (!rst);
    repeat (300) @(posedge clk);
    long_stall <= 1'b1;
    repeat (400) @(posedge clk);
    long_stall <= 1'b0;
  end

  // Watchdog: counts cycles in which nothing is accepted.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (seg_if.valid && seg_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [30:0] base;
    req_if.valid           <= 1'b0;
    req_if.opcode          <= OP_CLEAR;
    req_if.request_sector  <= '0;
    req_if.request_count   <= '0;
    req_if.request_addr    <= '0;
    req_if.entry_bad_first <= '0;
    req_if.entry_bad_last  <= '0;
    req_if.entry_alt_first <= '0;
    cfg_if.valid           <= 1'b0;
    cfg_if.sector_size     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: one cluster 100..109 remapped to 5000, and every way a
    // request can overlap it.
    remap(31'd7, 16'd4, 32'h1000);                    // empty table
    add_cluster(31'd100, 31'd109, 31'd5000);
    remap(31'd10, 16'd5, 32'h0);                      // wholly before
    remap(31'd200, 16'd5, 32'h0);                     // wholly after
    remap(31'd102, 16'd3, 32'h100);                   // wholly inside
    remap(31'd105, 16'd20, 32'h200);                  // starts inside, ends after
    remap(31'd95, 16'd8, 32'hffff_ff00);              // starts before, ends inside
    remap(31'd90, 16'd40, 32'hffff_fff0);             // spans the cluster
    remap(31'd100, 16'd10, 32'h0);                    // exactly the cluster
    remap(31'd100, 16'd0, 32'h0);                     // zero count
    remap(31'd0, 16'd0, 32'h0);                       // zero count at sector zero
    remap(31'h7fff_ffff, 16'hffff, 32'hffff_ffff);    // field maxima
    send_raw(OP_RESERVED);                            // unused opcode
    add_cluster(31'd300, 31'd290, 31'h7fff_ffff);     // last below first
    add_cluster(31'd50, 31'd60, 31'd0);               // out of order
    remap(31'd40, 16'd400, 32'h4000);
    // Overflow: many clusters spanned by one request.
    load_table(10, 31'd1000);
    remap(31'd990, 16'd200, 32'h0);
    // Table full, then the append that overflows it.
    load_table(64, 31'd20);
    add_cluster(31'd9999, 31'd9999, 31'd1);
    remap(31'd0, 16'd30, 32'h8000);
    send_request(OP_CLEAR, '0, '0, '0, '0, '0, '0);

    set_sector_size(16'd1);
    // Random phases: mostly remaps near a fresh ordered table, some noise.
    for (int ph = 0; ph < 4; ph++) begin
      base = 31'($urandom_range(0, 32'h7fff_f000));
      load_table(int'($urandom_range(1, 4)), base);
      for (int k = 0; k < 5; k++) begin
        case ($urandom_range(0, 9))
          0: send_raw(2'($urandom_range(0, 3)));
          1: remap(31'($urandom()), 16'($urandom()), $urandom());
          default: remap(base + 31'($urandom_range(0, 80)) - 31'd10,
                         ($urandom_range(0, 7) == 0) ? 16'($urandom()) :
                                                       16'($urandom_range(0, 60)),
                         $urandom());
        endcase
      end
      case (ph)
        0: set_sector_size(16'hffff);
        1: set_sector_size(16'($urandom_range(1, 16'hffff)));
        2: set_sector_size(16'd512);
        default: ;
      endcase
    end
    req_if.valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
rtl/bsr_pkg.sv
rtl/bsr_if.sv
rtl/bsr_ram.sv
rtl/bsr_datapath.sv
rtl/bsr_ctrl.sv
rtl/bad_sector_range_remapper.sv
rtl/bsr_checker.sv
tb/bsr_checker.sv
tb/tb_top.sv
